[rtl/symm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and Q16.16 helpers for the symmetric COO SpMM unit.
// No dependencies.
package symm_pkg;

   localparam int MAX_ROWS_DEF = 1024;
   localparam int MAX_COLS_DEF = 8;

   localparam int DATA_W    = 32;
   localparam int IDX_W     = 10;
   localparam int DCOL_W    = 3;
   localparam int CMD_W     = 2;
   localparam int CSR_IDX_W = 2;
   localparam int COUNT_W   = 4;

   localparam logic [CMD_W-1:0] CMD_LOAD_X  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_Y  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NONZERO = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ_Y  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS  = 2'd2;

   localparam logic signed [DATA_W-1:0] ALPHA_RESET = 32'sh0001_0000;
   localparam logic signed [DATA_W-1:0] BETA_RESET  = 32'sh0000_0000;
   localparam logic [COUNT_W-1:0]       COLS_RESET  = 4'd1;

   localparam logic signed [63:0] Q_MAX64 = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] Q_MIN64 = 64'shFFFF_FFFF_8000_0000;
   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MOD1,
      ST_MOD2,
      ST_ADDR,
      ST_XWR,
      ST_YMUL,
      ST_YWR,
      ST_RDREQ,
      ST_RESP,
      ST_TMUL,
      ST_TSAT,
      ST_RD1,
      ST_MUL1,
      ST_WR1,
      ST_RD2,
      ST_MUL2,
      ST_WR2
   } state_type;

   // Full product to Q16.16: floor shift by 16, then saturate.
   function automatic logic signed [DATA_W-1:0] q_trunc(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> 16;
      if (s > Q_MAX64) begin
         return Q_MAX;
      end else if (s < Q_MIN64) begin
         return Q_MIN;
      end
      return s[DATA_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] q_add(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] s;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         return s[DATA_W] ? Q_MIN : Q_MAX;
      end
      return s[DATA_W-1:0];
   endfunction

endpackage

[rtl/symm_coo_upper_spmm_unit.sv]
`timescale 1ns / 1ps
// Top level of the symmetric COO upper-triangle SpMM unit: Y = beta*Y + alpha*A*X.
// Depends on symm_pkg and symm_ram (one instance each for the X and Y stores).
//
// Usage:
//   req_* carries one transaction per command: load X, load Y (scaled by beta), nonzero
//   entry (row, column, value) of the upper triangle, or read Y. A transaction is taken
//   when req_valid is high and req_stall is low; the unit takes one at a time and raises
//   req_stall until it has finished with it.
//   rsp_* returns one transaction per read Y command, holding while rsp_stall is high.
//   The output register lets the unit go on with later commands while a read result waits;
//   a second read waits for the register to drain.
//   Commands step through states, paced by the single shared 32x32 multiplier and the one
//   read and one write port of each store. Read Y reads the Y store, then loads the output
//   register. A nonzero entry makes one pass per dense column in use, with one read, multiply
//   and write step on the diagonal and two above it; with no columns in use it is ignored.
//   csr_* writes alpha_gain, beta_gain and columns_in_use; write only while idle.
//   Reset (synchronous) restores the register defaults and clears the control state;
//   the stores hold no defined contents until written.
module symm_coo_upper_spmm_unit #(
   parameter int MAX_ROWS = symm_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = symm_pkg::MAX_COLS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [symm_pkg::CMD_W-1:0]          req_command,
   input  logic [symm_pkg::IDX_W-1:0]          req_row_index,
   input  logic [symm_pkg::IDX_W-1:0]          req_col_index,
   input  logic [symm_pkg::DCOL_W-1:0]         req_dense_col,
   input  logic signed [symm_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [symm_pkg::IDX_W-1:0]          rsp_out_row,
   output logic [symm_pkg::DCOL_W-1:0]         rsp_out_col,
   output logic signed [symm_pkg::DATA_W-1:0]  rsp_result_value,
   input  logic                                csr_wr_en,
   input  logic [symm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [symm_pkg::DATA_W-1:0]         csr_wdata
);

   import symm_pkg::*;

   localparam int DEPTH      = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int DC_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RECIP_ROW  = (1 << IDX_W) / MAX_ROWS;
   localparam int RECIP_COL  = (1 << DCOL_W) / MAX_COLS;

   state_type state_ff, state_in;

   // configuration
   logic signed [DATA_W-1:0] alpha_ff, beta_ff;
   logic [COUNT_W-1:0]       cols_ff;
   logic [COUNT_W-1:0]       ncols;

   // captured transaction
   logic [CMD_W-1:0]         cmd_ff;
   logic [IDX_W-1:0]         row_ff, col_ff;
   logic [DCOL_W-1:0]        dcol_ff;
   logic signed [DATA_W-1:0] val_ff;

   // index wrap
   logic [IDX_W-1:0]         qr_ff, qc_ff;
   logic [DCOL_W-1:0]        qd_ff;
   logic [ROW_W-1:0]         rowm_ff, colm_ff;
   logic [DC_W-1:0]          dcm_ff;
   logic [31:0]              rr_w, rc_w, rd_w;

   // addressing and loop
   logic [ADDR_W-1:0]        addr_ff, base_ff;
   logic [ADDR_W-1:0]        row_addr, col_addr;
   logic [COUNT_W-1:0]       k_ff;
   logic                     last_col;
   logic                     diag;

   // arithmetic
   logic signed [DATA_W-1:0] mul_a, mul_b;
   logic signed [63:0]       prod_ff;
   logic signed [DATA_W-1:0] t_ff;

   // memories
   logic                     x_wr_en, x_rd_en, y_wr_en, y_rd_en;
   logic [ADDR_W-1:0]        x_wr_addr, x_rd_addr, y_wr_addr, y_rd_addr;
   logic [DATA_W-1:0]        x_wr_data, y_wr_data, x_rd_data, y_rd_data;
   logic signed [DATA_W-1:0] y_upd;

   // output register
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_row_ff;
   logic [DCOL_W-1:0]        rsp_col_ff;
   logic signed [DATA_W-1:0] rsp_val_ff;
   logic                     rsp_load;

   assign ncols    = (32'(cols_ff) > 32'(MAX_COLS)) ? COUNT_W'(MAX_COLS) : cols_ff;
   assign diag     = (col_ff == row_ff);
   assign row_addr = base_ff + ADDR_W'(rowm_ff);
   assign col_addr = base_ff + ADDR_W'(colm_ff);
   assign last_col = ({1'b0, k_ff} + 5'd1) == {1'b0, ncols};
   assign y_upd    = q_add($signed(y_rd_data), q_trunc(prod_ff));
   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);

   // wrap indices: reciprocal estimate is low by at most one
   always_comb begin
      rr_w = 32'(row_ff) - 32'(qr_ff) * 32'(MAX_ROWS);
      if (rr_w >= 32'(MAX_ROWS)) begin
         rr_w = rr_w - 32'(MAX_ROWS);
      end
      rc_w = 32'(col_ff) - 32'(qc_ff) * 32'(MAX_ROWS);
      if (rc_w >= 32'(MAX_ROWS)) begin
         rc_w = rc_w - 32'(MAX_ROWS);
      end
      rd_w = 32'(dcol_ff) - 32'(qd_ff) * 32'(MAX_COLS);
      if (rd_w >= 32'(MAX_COLS)) begin
         rd_w = rd_w - 32'(MAX_COLS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      mul_a     = '0;
      mul_b     = '0;
      x_wr_en   = 1'b0;
      x_wr_addr = addr_ff;
      x_wr_data = val_ff;
      x_rd_en   = 1'b0;
      x_rd_addr = col_addr;
      y_wr_en   = 1'b0;
      y_wr_addr = row_addr;
      y_wr_data = y_upd;
      y_rd_en   = 1'b0;
      y_rd_addr = row_addr;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_MOD1;
            end
         end
         ST_MOD1: state_in = ST_MOD2;
         ST_MOD2: begin
            if (cmd_ff == CMD_NONZERO) begin
               if (col_ff < row_ff || ncols == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_TMUL;
               end
            end else begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            case (cmd_ff)
               CMD_LOAD_X: state_in = ST_XWR;
               CMD_LOAD_Y: state_in = ST_YMUL;
               default:    state_in = ST_RDREQ;
            endcase
         end
         ST_XWR: begin
            x_wr_en  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_YMUL: begin
            mul_a    = val_ff;
            mul_b    = beta_ff;
            state_in = ST_YWR;
         end
         ST_YWR: begin
            y_wr_en   = 1'b1;
            y_wr_addr = addr_ff;
            y_wr_data = q_trunc(prod_ff);
            state_in  = ST_IDLE;
         end
         ST_RDREQ: begin
            y_rd_en   = 1'b1;
            y_rd_addr = addr_ff;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         ST_TMUL: begin
            mul_a    = alpha_ff;
            mul_b    = val_ff;
            state_in = ST_TSAT;
         end
         ST_TSAT: state_in = ST_RD1;
         ST_RD1: begin
            x_rd_en   = 1'b1;
            x_rd_addr = col_addr;
            y_rd_en   = 1'b1;
            y_rd_addr = row_addr;
            state_in  = ST_MUL1;
         end
         ST_MUL1: begin
            mul_a    = t_ff;
            mul_b    = $signed(x_rd_data);
            state_in = ST_WR1;
         end
         ST_WR1: begin
            y_wr_en   = 1'b1;
            y_wr_addr = row_addr;
            if (!diag) begin
               state_in = ST_RD2;
            end else if (last_col) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RD1;
            end
         end
         ST_RD2: begin
            x_rd_en   = 1'b1;
            x_rd_addr = row_addr;
            y_rd_en   = 1'b1;
            y_rd_addr = col_addr;
            state_in  = ST_MUL2;
         end
         ST_MUL2: begin
            mul_a    = t_ff;
            mul_b    = $signed(x_rd_data);
            state_in = ST_WR2;
         end
         ST_WR2: begin
            y_wr_en   = 1'b1;
            y_wr_addr = col_addr;
            state_in  = last_col ? ST_IDLE : ST_RD1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         beta_ff  <= BETA_RESET;
         cols_ff  <= COLS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ALPHA: alpha_ff <= $signed(csr_wdata);
            CSR_BETA:  beta_ff  <= $signed(csr_wdata);
            CSR_COLS:  cols_ff  <= csr_wdata[COUNT_W-1:0];
            default:   ;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (state_ff == ST_IDLE && req_valid) begin
         cmd_ff  <= req_command;
         row_ff  <= req_row_index;
         col_ff  <= req_col_index;
         dcol_ff <= req_dense_col;
         val_ff  <= req_value;
      end
      if (state_ff == ST_MOD1) begin
         qr_ff <= IDX_W'((32'(row_ff) * 32'(RECIP_ROW)) >> IDX_W);
         qc_ff <= IDX_W'((32'(col_ff) * 32'(RECIP_ROW)) >> IDX_W);
         qd_ff <= DCOL_W'((32'(dcol_ff) * 32'(RECIP_COL)) >> DCOL_W);
      end
      if (state_ff == ST_MOD2) begin
         rowm_ff <= ROW_W'(rr_w);
         colm_ff <= ROW_W'(rc_w);
         dcm_ff  <= DC_W'(rd_w);
      end
      if (state_ff == ST_ADDR) begin
         addr_ff <= ADDR_W'(32'(dcm_ff) * 32'(MAX_ROWS)) + ADDR_W'(rowm_ff);
      end
      if (state_ff == ST_TSAT) begin
         t_ff    <= q_trunc(prod_ff);
         base_ff <= '0;
         k_ff    <= '0;
      end
      // advance to the next dense column
      if ((state_ff == ST_WR1 && diag) || state_ff == ST_WR2) begin
         base_ff <= base_ff + ADDR_W'(MAX_ROWS);
         k_ff    <= k_ff + COUNT_W'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_row_ff <= row_ff;
         rsp_col_ff <= dcol_ff;
         rsp_val_ff <= $signed(y_rd_data);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_row      = rsp_row_ff;
   assign rsp_out_col      = rsp_col_ff;
   assign rsp_result_value = rsp_val_ff;

   symm_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_x_ram (
      .clock  (clock),
      .wr_en  (x_wr_en),
      .wr_addr(x_wr_addr),
      .wr_data(x_wr_data),
      .rd_en  (x_rd_en),
      .rd_addr(x_rd_addr),
      .rd_data(x_rd_data)
   );

   symm_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_y_ram (
      .clock  (clock),
      .wr_en  (y_wr_en),
      .wr_addr(y_wr_addr),
      .wr_data(y_wr_data),
      .rd_en  (y_rd_en),
      .rd_addr(y_rd_addr),
      .rd_data(y_rd_data)
   );

endmodule

[rtl/symm_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module symm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
